// ===== rtl/core/stb_pkg.sv =====
package stb_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CHANNELS_MAX = 32;
  localparam int OP_W         = 3;
  localparam int CH_W         = 3;
  localparam int PERIOD_W     = 16;
  localparam int MASK_W       = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_INSTALL = 3'd1,
    OP_OPEN    = 3'd2,
    OP_CLOSE   = 3'd3,
    OP_FREE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic                fire;
    logic [PERIOD_W-1:0] count;
  } stb_alu_res_t;

endpackage

// ===== rtl/core/stb_alu.sv =====
module stb_alu (
  input  logic [stb_pkg::PERIOD_W-1:0] count,
  input  logic [stb_pkg::PERIOD_W-1:0] period,
  output stb_pkg::stb_alu_res_t        res
);
  import stb_pkg::*;

  always_comb begin
    res.fire  = (count == period);
    res.count = res.fire ? '0 : count + PERIOD_W'(1);
  end

endmodule

// ===== rtl/core/stb_mem.sv =====
module stb_mem #(
  parameter int CHANNELS = stb_pkg::CHANNELS_DEF,
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                         clk,
  input  logic [IDX_W-1:0]             addr,
  input  logic                         we_period,
  input  logic                         we_count,
  input  logic [stb_pkg::PERIOD_W-1:0] wr_period,
  input  logic [stb_pkg::PERIOD_W-1:0] wr_count,
  output logic [stb_pkg::PERIOD_W-1:0] rd_period,
  output logic [stb_pkg::PERIOD_W-1:0] rd_count
);
  import stb_pkg::*;

  logic [PERIOD_W-1:0] period_mem [CHANNELS];
  logic [PERIOD_W-1:0] count_mem  [CHANNELS];
  logic [PERIOD_W-1:0] rd_period_r;
  logic [PERIOD_W-1:0] rd_count_r;

  always_ff @(posedge clk) begin
    if (we_period) begin
      period_mem[addr] <= wr_period;
    end
    if (we_count) begin
      count_mem[addr] <= wr_count;
    end
    rd_period_r <= period_mem[addr];
    rd_count_r  <= count_mem[addr];
  end

  assign rd_period = rd_period_r;
  assign rd_count  = rd_count_r;

endmodule

// ===== rtl/core/soft_timer_bank.sv =====
// Bank of periodic timer channels driven by command beats.
// A command beat (in_op, in_channel, in_period) is taken at a rising edge where
// start is high and busy is low. Every command gives exactly one result beat:
// out_fired_mask is valid for the single cycle in which out_valid is high.
// Install, open, close and free act on one channel, and their
// result, always zero, is set in the EXEC state and registered into out_valid.
// A tick walks all channels through one shared compare and increment unit,
// with a registered table read (RD) and a write back (UPD) per channel, and
// its result is registered into out_valid after the last write back.
// Busy is high from the cycle after a command is taken until its result is
// shown; a new command may be taken in the cycle its result is shown.
// The receiver cannot stall, so every result is delivered when it is shown.
// Reset marks all channels free and stopped and clears the sequencer.
// The period and count tables are not cleared: a tick reads every entry but
// writes and flags only installed, running channels; install writes both.
module soft_timer_bank #(
  parameter int CHANNELS = stb_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [stb_pkg::OP_W-1:0]     in_op,
  input  logic [stb_pkg::CH_W-1:0]     in_channel,
  input  logic [stb_pkg::PERIOD_W-1:0] in_period,
  output logic                         out_valid,
  output logic [stb_pkg::MASK_W-1:0]   out_fired_mask
);
  import stb_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r;
  logic [CH_W-1:0]     ch_r;
  logic [PERIOD_W-1:0] period_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [CHANNELS-1:0] alloc_r, alloc_nxt;
  logic [CHANNELS-1:0] run_r, run_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;

  logic [IDX_W-1:0]    mem_addr;
  logic                we_period, we_count;
  logic [PERIOD_W-1:0] wr_count;
  logic [PERIOD_W-1:0] rd_period, rd_count;
  stb_alu_res_t        alu_res;

  logic                accept;
  logic                ch_ok;
  logic [IDX_W-1:0]    ch_idx;
  logic                active;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE) || !rst_n;
  assign ch_ok  = (int'(ch_r) < CHANNELS);
  assign ch_idx = IDX_W'(ch_r);
  assign active = alloc_r[idx_r] && run_r[idx_r];

  stb_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk       (clk),
    .addr      (mem_addr),
    .we_period (we_period),
    .we_count  (we_count),
    .wr_period (period_r),
    .wr_count  (wr_count),
    .rd_period (rd_period),
    .rd_count  (rd_count)
  );

  stb_alu u_alu (
    .count  (rd_count),
    .period (rd_period),
    .res    (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alloc_r     <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      alloc_r     <= alloc_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r <= out_mask_nxt;
    if (accept) begin
      op_r     <= in_op;
      ch_r     <= in_channel;
      period_r <= in_period;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    alloc_nxt     = alloc_r;
    run_nxt       = run_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_mask_nxt  = out_mask_r;
    mem_addr      = idx_r;
    we_period     = 1'b0;
    we_count      = 1'b0;
    wr_count      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          mask_nxt  = '0;
          state_nxt = (in_op == OP_TICK) ? ST_RD : ST_EXEC;
        end
      end
      ST_EXEC: begin
        mem_addr = ch_idx;
        if (ch_ok) begin
          unique case (op_r)
            OP_INSTALL: begin
              if (!alloc_r[ch_idx]) begin
                we_period         = 1'b1;
                we_count          = 1'b1;
                alloc_nxt[ch_idx] = 1'b1;
                run_nxt[ch_idx]   = 1'b1;
              end
            end
            OP_OPEN:  run_nxt[ch_idx]   = 1'b1;
            OP_CLOSE: run_nxt[ch_idx]   = 1'b0;
            OP_FREE:  alloc_nxt[ch_idx] = 1'b0;
            default: ;
          endcase
        end
        out_valid_nxt = 1'b1;
        out_mask_nxt  = '0;
        state_nxt     = ST_IDLE;
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        wr_count = alu_res.count;
        if (active) begin
          we_count = 1'b1;
          if (alu_res.fire && (int'(idx_r) < MASK_W)) begin
            mask_nxt[3'(idx_r)] = 1'b1;
          end
        end
        if (idx_r == IDX_W'(CHANNELS - 1)) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = mask_nxt;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = out_mask_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after a command beat was taken");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_EXEC || $past(state_r) == ST_UPD))
    else $error("result beat without a finishing sequencer step");

  a_nontick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r != OP_TICK) |-> (out_fired_mask == '0))
    else $error("non-tick command reported fired channels");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat shown while the sequencer is still busy");
`endif

endmodule
